>>> hdl/spit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seek point index table package
// Shared codes, field widths and defaults for the seek point index table.
// ----------------------------------------------------------------------------
package spit_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_POS_BITS    = 48;

	localparam int FIELD_W    = 48;
	localparam int COUNT_W    = 11;
	localparam int IN_DATA_W  = 2 * FIELD_W;
	localparam int OUT_DATA_W = 208;
	localparam int OUT_PAD_W  = OUT_DATA_W - 4 * FIELD_W - COUNT_W;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_res_t;

endpackage

>>> hdl/spit_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seek point store
// One write port, one registered read port; entries hold {upos, cpos}.
// ----------------------------------------------------------------------------
module spit_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/spit_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor search sequencer
// Binary search over the store with one shared magnitude comparator.
// ----------------------------------------------------------------------------
module spit_search
	import spit_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int POS_BITS    = DEF_POS_BITS,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CW-1:0]         len,
	input  logic [POS_BITS-1:0]   target,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  logic [2*POS_BITS-1:0] rd_data,
	output srch_res_t             res,
	output logic [POS_BITS-1:0]   ent_cpos,
	output logic [POS_BITS-1:0]   ent_upos
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_RD_MID,
		S_CMP_MID,
		S_RD_NXT,
		S_CMP_NXT
	} state_t;

	state_t              state_q;
	logic                done_q;
	logic                hit_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       mid_q;
	logic [CW-1:0]       len_q;
	logic [POS_BITS-1:0] target_q;
	logic [POS_BITS-1:0] cpos_q;
	logic [POS_BITS-1:0] upos_q;

	logic [CW:0]         sum;
	logic [CW-1:0]       nxt;
	logic                has_nxt;
	logic                gt;

	assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign nxt     = mid_q + CW'(1);
	assign has_nxt = nxt < len_q;
	// shared compare: probed entry's upos above the target
	assign gt      = rd_data[2*POS_BITS-1:POS_BITS] > target_q;

	assign rd_en   = (state_q == S_RD_MID) || (state_q == S_RD_NXT);
	assign rd_addr = (state_q == S_RD_NXT) ? nxt[AW-1:0] : mid_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (len == '0) begin
							done_q <= 1'b1;
							hit_q  <= 1'b0;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (lo_q > hi_q) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD_MID;
					end
				end
				S_RD_MID: state_q <= S_CMP_MID;
				S_CMP_MID: begin
					if (gt) begin
						if (mid_q == '0) begin
							done_q  <= 1'b1;
							hit_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PROBE;
						end
					end else if (has_nxt) begin
						state_q <= S_RD_NXT;
					end else begin
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RD_NXT: state_q <= S_CMP_NXT;
				S_CMP_NXT: begin
					if (!gt) begin
						state_q <= S_PROBE;
					end else begin
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_q     <= '0;
					hi_q     <= len - CW'(1);
					len_q    <= len;
					target_q <= target;
				end
			end
			S_PROBE: mid_q <= sum[CW:1];
			S_CMP_MID: begin
				cpos_q <= rd_data[POS_BITS-1:0];
				upos_q <= rd_data[2*POS_BITS-1:POS_BITS];
				if (gt) begin
					hi_q <= mid_q - CW'(1);
				end
			end
			S_CMP_NXT: begin
				if (!gt) begin
					lo_q <= nxt;
				end
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.hit  = hit_q;
	assign ent_cpos = cpos_q;
	assign ent_upos = upos_q;

endmodule

>>> hdl/seek_point_index_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seek point index table unit
// Append, clear and floor lookup over a table of seek points.
// ----------------------------------------------------------------------------
// Append, clear and the unused action pass through ST_DONE to the output register.
// A lookup is a binary search in which every probe reads the single store
// port once or twice. One item is in work at a time; a new item is taken
// while the previous result still waits in the output register.
module seek_point_index_table_unit
	import spit_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int POS_BITS    = DEF_POS_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// compressed_pos [47:0], uncompressed_pos [95:48]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action [1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// frame_start [47:0], inner_offset [95:48], found_uncompressed [143:96],
	// known_size [191:144], entry_count [202:192], zero [207:203]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [1:0]            m_axis_tuser
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;
	action_t               act_q;
	status_t               status_q;
	logic [POS_BITS-1:0]   target_q;
	logic [POS_BITS-1:0]   last_upos_q;
	logic                  hit_q;

	logic                  acc;
	action_t               act_in;
	logic [POS_BITS-1:0]   cpos_in;
	logic [POS_BITS-1:0]   upos_in;
	logic                  full;
	logic                  mem_we;
	logic                  out_ld;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [2*POS_BITS-1:0] rd_data;
	srch_res_t             srch_res;
	logic [POS_BITS-1:0]   ent_cpos;
	logic [POS_BITS-1:0]   ent_upos;

	status_t               r_status;
	logic [POS_BITS-1:0]   r_fstart;
	logic [POS_BITS-1:0]   r_inner;
	logic [POS_BITS-1:0]   r_found;
	logic [POS_BITS-1:0]   r_known;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign act_in        = action_t'(s_axis_tuser);
	assign cpos_in       = POS_BITS'(s_axis_tdata[FIELD_W-1:0]);
	assign upos_in       = POS_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
	assign full          = (count_q == CW'(TABLE_DEPTH));
	assign mem_we        = acc && (act_in == ACT_APPEND) && !full;
	assign out_ld        = (state_q == ST_DONE) && (!m_tvalid_q || m_axis_tready);

	spit_store #(
		.DEPTH  (TABLE_DEPTH),
		.DATA_W (2 * POS_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({upos_in, cpos_in}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	spit_search #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.POS_BITS    (POS_BITS)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && (act_in == ACT_LOOKUP)),
		.len      (count_q),
		.target   (upos_in),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (srch_res),
		.ent_cpos (ent_cpos),
		.ent_upos (ent_upos)
	);

	always_comb begin
		r_status = status_q;
		r_fstart = '0;
		r_inner  = '0;
		r_found  = '0;
		r_known  = (count_q == '0) ? '0 : last_upos_q;
		case (act_q)
			ACT_LOOKUP: begin
				if (hit_q) begin
					r_status = STAT_OK;
					r_fstart = ent_cpos;
					r_found  = ent_upos;
					r_inner  = target_q - ent_upos;
				end else begin
					r_status = STAT_MISS;
					r_inner  = target_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (act_in)
							ACT_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_DONE;
							end
							ACT_LOOKUP: state_q <= ST_LOOK;
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOOK: begin
					if (srch_res.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ld) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q    <= act_in;
			target_q <= upos_in;
			status_q <= ((act_in == ACT_APPEND) && full) ? STAT_FULL : STAT_OK;
		end
		if (mem_we) begin
			last_upos_q <= upos_in;
		end
		if ((state_q == ST_LOOK) && srch_res.done) begin
			hit_q <= srch_res.hit;
		end
		if (out_ld) begin
			m_tuser_q <= r_status;
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, COUNT_W'(count_q), FIELD_W'(r_known),
				FIELD_W'(r_found), FIELD_W'(r_inner), FIELD_W'(r_fstart)};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_done_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> state_q == ST_LOOK)
		else $error("search result outside lookup");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_en)
		else $error("store write during search read");

	a_look_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (act_in == ACT_LOOKUP) |=> state_q == ST_LOOK)
		else $error("lookup transfer did not start search");

endmodule

>>> tb/sv/tb_seek_point_index_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seek point index table unit testbench
// Runs directed and random append, lookup and clear streams through the unit,
// predicts every result with a shadow table and a floor search, and checks
// each output transfer field by field. Random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_seek_point_index_table_unit;
	import spit_pkg::*;

	localparam int          TABLE_DEPTH  = DEF_TABLE_DEPTH;
	localparam logic [1:0]  ACT_NOP      = 2'd3;
	localparam logic [47:0] POS_MAX      = 48'hFFFF_FFFF_FFFF;
	localparam int          LIMIT_CYCLES = 2_000_000;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          RANDOM_ITEMS = 100;

	typedef struct {
		status_t     status;
		logic [47:0] frame_start;
		logic [47:0] inner_offset;
		logic [47:0] found_unc;
		logic [47:0] known_size;
		logic [10:0] entry_count;
	} seek_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// compressed_pos [47:0], uncompressed_pos [95:48]
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// action [1:0]
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// frame_start [47:0], inner_offset [95:48], found_uncompressed [143:96],
	// known_size [191:144], entry_count [202:192], zero [207:203]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// status [1:0]
	logic [1:0]            m_axis_tuser;

	logic [47:0]  shadow_cpos [TABLE_DEPTH];
	logic [47:0]  shadow_upos [TABLE_DEPTH];
	int           fill_shadow = 0;
	seek_result_t pending_results [$];
	int           err_cnt = 0;
	bit           calm_tx = 1'b0;
	bit           calm_rx = 1'b0;
	int           stall_left = 0;

	seek_point_index_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic int pick_idle(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// last entry at or below target, -1 if none; same probe order as the unit
	function automatic int floor_index(input logic [47:0] target);
		int lo;
		int hi;
		int mid;
		if (fill_shadow == 0) begin
			return -1;
		end
		lo = 0;
		hi = fill_shadow - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (shadow_upos[mid] > target) begin
				if (mid == 0) begin
					return -1;
				end
				hi = mid - 1;
			end else if (mid + 1 < fill_shadow && shadow_upos[mid + 1] <= target) begin
				lo = mid + 1;
			end else begin
				return mid;
			end
		end
		return -1;
	endfunction

	function automatic seek_result_t predict_seek(input logic [1:0] act,
			input logic [47:0] cpos, input logic [47:0] upos);
		seek_result_t r;
		int idx;
		r.status       = STAT_OK;
		r.frame_start  = '0;
		r.inner_offset = '0;
		r.found_unc    = '0;
		case (act)
		ACT_APPEND: begin
			if (fill_shadow >= TABLE_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				shadow_cpos[fill_shadow] = cpos;
				shadow_upos[fill_shadow] = upos;
				fill_shadow++;
			end
		end
		ACT_LOOKUP: begin
			idx = floor_index(upos);
			if (idx < 0) begin
				r.status       = STAT_MISS;
				r.inner_offset = upos;
			end else begin
				r.frame_start  = shadow_cpos[idx];
				r.found_unc    = shadow_upos[idx];
				r.inner_offset = upos - shadow_upos[idx];
			end
		end
		ACT_CLEAR: begin
			fill_shadow = 0;
		end
		default: begin
		end
		endcase
		r.known_size  = (fill_shadow == 0) ? 48'd0 : shadow_upos[fill_shadow - 1];
		r.entry_count = fill_shadow[10:0];
		return r;
	endfunction

	function automatic logic [47:0] pick_target();
		int r;
		int i;
		logic [47:0] u;
		r = $urandom_range(0, 9);
		if (fill_shadow == 0 || r == 0) begin
			return rand48();
		end
		i = $urandom_range(0, fill_shadow - 1);
		u = shadow_upos[i];
		case (r)
		1, 2, 3: return u;
		4, 5:    return u - 48'd1;
		6, 7:    return u + 48'd1;
		8:       return u + 48'($urandom_range(0, 5000));
		default: return $urandom_range(0, 1) ? 48'd0 : POS_MAX;
		endcase
	endfunction

	task automatic send_seek(input logic [1:0] act, input logic [47:0] cpos,
			input logic [47:0] upos);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {upos, cpos};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		pending_results.push_back(predict_seek(act, cpos, upos));
		gap = pick_idle(calm_tx);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// output side: check each transfer, then pick the next ready value
	always @(posedge clk) begin
		seek_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, actual status %0h data %0h", $time,
					m_axis_tuser, m_axis_tdata);
				err_cnt++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 64'(exp_r.status), 64'(m_axis_tuser));
				check_field("frame_start", 64'(exp_r.frame_start), 64'(m_axis_tdata[47:0]));
				check_field("inner_offset", 64'(exp_r.inner_offset), 64'(m_axis_tdata[95:48]));
				check_field("found_uncompressed", 64'(exp_r.found_unc),
					64'(m_axis_tdata[143:96]));
				check_field("known_size", 64'(exp_r.known_size), 64'(m_axis_tdata[191:144]));
				check_field("entry_count", 64'(exp_r.entry_count), 64'(m_axis_tdata[202:192]));
				check_field("pad", 64'd0, 64'(m_axis_tdata[207:203]));
			end
		end
		if ($urandom_range(0, 199) == 0) begin
			calm_rx = ($urandom_range(0, 2) == 0);
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm_rx && $urandom_range(0, 99) < 25) begin
				stall_left = pick_idle(1'b0);
			end
		end
	end

	task automatic test_empty_table();
		send_seek(ACT_LOOKUP, rand48(), 48'd0);
		send_seek(ACT_LOOKUP, rand48(), POS_MAX);
	endtask

	task automatic test_append_extremes();
		send_seek(ACT_APPEND, POS_MAX, 48'd0);
		send_seek(ACT_APPEND, 48'd0, 48'h8000_0000_0000);
		send_seek(ACT_APPEND, 48'h5A5A_A5A5_5A5A, POS_MAX);
		send_seek(ACT_LOOKUP, POS_MAX, 48'd0);
		send_seek(ACT_LOOKUP, 48'd0, POS_MAX);
		send_seek(ACT_LOOKUP, POS_MAX, POS_MAX - 48'd1);
	endtask

	task automatic test_unused_action();
		send_seek(ACT_NOP, POS_MAX, POS_MAX);
	endtask

	task automatic test_clear();
		send_seek(ACT_CLEAR, POS_MAX, POS_MAX);
		send_seek(ACT_LOOKUP, 48'd0, 48'd12345);
		send_seek(ACT_NOP, rand48(), rand48());
	endtask

	task automatic test_below_first();
		send_seek(ACT_APPEND, 48'd10, 48'd1000);
		send_seek(ACT_LOOKUP, 48'd0, 48'd999);
		send_seek(ACT_LOOKUP, 48'd0, 48'd1000);
	endtask

	task automatic test_unsorted_appends();
		send_seek(ACT_CLEAR, 48'd0, 48'd0);
		send_seek(ACT_APPEND, 48'd1, 48'd500);
		send_seek(ACT_APPEND, 48'd2, 48'd100);
		send_seek(ACT_APPEND, 48'd3, 48'd900);
		send_seek(ACT_APPEND, 48'd4, 48'd300);
		send_seek(ACT_LOOKUP, 48'd0, 48'd350);
		send_seek(ACT_LOOKUP, 48'd0, 48'd50);
		send_seek(ACT_LOOKUP, 48'd0, 48'd950);
	endtask

	task automatic test_table_full();
		logic [47:0] cur;
		send_seek(ACT_CLEAR, 48'd0, 48'd0);
		cur = 48'($urandom_range(0, 100));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_seek(ACT_APPEND, rand48(), cur);
			cur = cur + 48'($urandom_range(0, 1 << 20));
		end
		send_seek(ACT_APPEND, rand48(), cur);
		send_seek(ACT_APPEND, POS_MAX, POS_MAX);
		send_seek(ACT_LOOKUP, 48'd0, 48'd0);
		send_seek(ACT_LOOKUP, 48'd0, POS_MAX);
		send_seek(ACT_LOOKUP, 48'd0, shadow_upos[0]);
		send_seek(ACT_LOOKUP, 48'd0, shadow_upos[TABLE_DEPTH - 1]);
		for (int i = 0; i < 40; i++) begin
			send_seek(ACT_LOOKUP, rand48(), pick_target());
		end
		send_seek(ACT_NOP, rand48(), rand48());
		send_seek(ACT_CLEAR, rand48(), rand48());
	endtask

	task automatic test_random_mix(input int n_items);
		int sent;
		int kind;
		int n;
		logic [47:0] cur;
		logic [47:0] step;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0) begin
				calm_tx = ($urandom_range(0, 3) == 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				if (fill_shadow > 250) begin
					send_seek(ACT_CLEAR, rand48(), rand48());
					sent++;
				end
				if (fill_shadow == 0) begin
					cur = $urandom_range(0, 1) ? 48'd0 : (rand48() >> $urandom_range(0, 47));
				end else begin
					cur = shadow_upos[fill_shadow - 1];
				end
				n = $urandom_range(1, 16);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 9))
					0:       step = 48'd0;
					1:       step = rand48() >> $urandom_range(8, 40);
					default: step = 48'($urandom_range(1, 1000));
					endcase
					cur = cur + step;
					send_seek(ACT_APPEND, rand48(), cur);
					sent++;
				end
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					send_seek(ACT_LOOKUP, rand48(), pick_target());
					sent++;
				end
			end else if (kind < 78) begin
				send_seek(ACT_CLEAR, rand48(), rand48());
				sent++;
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					send_seek(2'($urandom_range(0, 3)), rand48(), rand48());
					sent++;
				end
			end
		end
	endtask

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("seek_point_index_table_unit regression: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_append_extremes();
		test_unused_action();
		test_clear();
		test_below_first();
		test_unsorted_appends();
		test_table_full();
		test_random_mix(RANDOM_ITEMS);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("seek_point_index_table_unit regression: pass");
		end else begin
			$display("seek_point_index_table_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> seek_point_index_table_unit.f
hdl/spit_pkg.sv
hdl/spit_store.sv
hdl/spit_search.sv
hdl/seek_point_index_table_unit.sv
tb/sv/tb_seek_point_index_table_unit.sv
